/* rtl/b64se_pkg.sv */
// ----------------------------------------------------------------------------
// b64se_pkg
// Shared types, constants and the alphabet lookup of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned SEXTET_W   = 6;
    localparam int unsigned GROUP_W    = 3 * BYTE_W;
    localparam int unsigned PADS_W     = 2;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned CHARS_PER_GROUP = 4;
    localparam int unsigned CHAR_IDX_W = 2;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;   // '='

    // bytes held for the group being collected
    localparam logic [PHASE_W-1:0] PHASE_EMPTY = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONE   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_TWO   = 2'd2;

    // number of trailing '=' characters
    localparam logic [PADS_W-1:0] PADS_NONE = 2'd0;
    localparam logic [PADS_W-1:0] PADS_ONE  = 2'd1;
    localparam logic [PADS_W-1:0] PADS_TWO  = 2'd2;

    typedef struct packed {
        logic [GROUP_W-1:0] triple;
        logic [PADS_W-1:0]  pads;
        logic               last;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] idx);
        logic [CHAR_W-1:0] res;
        if (idx < 6'd26) begin
            res = 7'h41 + CHAR_W'(idx);
        end else if (idx < 6'd52) begin
            res = 7'h61 + CHAR_W'(idx - 6'd26);
        end else if (idx < 6'd62) begin
            res = 7'h30 + CHAR_W'(idx - 6'd52);
        end else if (idx == 6'd62) begin
            res = 7'h2B;
        end else begin
            res = 7'h2F;
        end
        return res;
    endfunction

endpackage

/* rtl/b64se_front.sv */
// ----------------------------------------------------------------------------
// b64se_front
// Collects message bytes into three-byte groups and pushes each complete or
// final partial group, with its pad count, into the group queue.
// ----------------------------------------------------------------------------
module b64se_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [b64se_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                         i_final_byte,
    input  b64se_pkg::t_queue_status     i_q_status,
    output logic                         o_push,
    output b64se_pkg::t_group            o_group
);
    import b64se_pkg::*;

    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [2*BYTE_W-1:0]    r_pending, n_pending;
    logic                   accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        o_push     = 1'b0;
        o_group    = '0;
        case (r_phase)
            PHASE_ONE: begin
                o_group.triple = {r_pending[2*BYTE_W-1:BYTE_W], i_data_byte, {BYTE_W{1'b0}}};
                o_group.pads   = PADS_ONE;
                o_group.last   = 1'b1;
                if (accept) begin
                    n_pending = {r_pending[2*BYTE_W-1:BYTE_W], i_data_byte};
                    if (i_final_byte) begin
                        o_push  = 1'b1;
                        n_phase = PHASE_EMPTY;
                    end else begin
                        n_phase = PHASE_TWO;
                    end
                end
            end
            PHASE_TWO: begin
                o_group.triple = {r_pending, i_data_byte};
                o_group.pads   = PADS_NONE;
                o_group.last   = i_final_byte;
                if (accept) begin
                    o_push    = 1'b1;
                    n_phase   = PHASE_EMPTY;
                end
            end
            default: begin
                // phase three cannot arise and behaves as empty
                o_group.triple = {i_data_byte, {(2*BYTE_W){1'b0}}};
                o_group.pads   = PADS_TWO;
                o_group.last   = 1'b1;
                if (accept) begin
                    n_pending = {i_data_byte, {BYTE_W{1'b0}}};
                    if (i_final_byte) begin
                        o_push  = 1'b1;
                        n_phase = PHASE_EMPTY;
                    end else begin
                        n_phase = PHASE_ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_EMPTY;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
    end

endmodule

/* rtl/b64se_queue.sv */
// ----------------------------------------------------------------------------
// b64se_queue
// Small first-in first-out queue of pending groups between front and back.
// ----------------------------------------------------------------------------
module b64se_queue #(
    parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  b64se_pkg::t_group        i_group,
    input  logic                     i_pop,
    output b64se_pkg::t_group        o_group,
    output b64se_pkg::t_queue_status o_status
);
    import b64se_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_group = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

/* rtl/b64se_back.sv */
// ----------------------------------------------------------------------------
// b64se_back
// Takes groups from the queue and emits their four characters, one per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module b64se_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b64se_pkg::t_queue_status     i_q_status,
    input  b64se_pkg::t_group            i_group,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b64se_pkg::CHAR_W-1:0] o_code_char,
    output logic                         o_last_char
);
    import b64se_pkg::*;

    t_group                 r_group;
    logic                   r_busy, n_busy;
    logic [CHAR_IDX_W-1:0]  r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;
    logic                   out_free, emit, group_done;
    logic [SEXTET_W-1:0]    sextet;
    logic                   is_pad;

    assign out_free   = !r_out_valid || i_ready;
    assign emit       = r_busy && out_free;
    assign group_done = emit && (r_idx == CHAR_IDX_W'(CHARS_PER_GROUP - 1));
    assign o_pop      = (!r_busy || group_done) && !i_q_status.empty;

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_group.triple[4*SEXTET_W-1:3*SEXTET_W];
            2'd1:    sextet = r_group.triple[3*SEXTET_W-1:2*SEXTET_W];
            2'd2:    sextet = r_group.triple[2*SEXTET_W-1:SEXTET_W];
            default: sextet = r_group.triple[SEXTET_W-1:0];
        endcase
        // pads fill the tail of the group
        is_pad = ((r_group.pads == PADS_TWO) && (r_idx >= 2'd2))
              || ((r_group.pads == PADS_ONE) && (r_idx == 2'd3));
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = is_pad ? PAD_CHAR : sextet_to_char(sextet);
            n_last      = r_group.last && (r_idx == CHAR_IDX_W'(CHARS_PER_GROUP - 1));
            n_idx       = r_idx + 1'b1;
        end
        if (group_done) begin
            n_busy = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        if (o_pop) begin
            r_group <= i_group;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_char = r_char;
    assign o_last_char = r_last;

endmodule

/* rtl/base64_stream_encoder_core.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
// Bytes enter one per transaction, the last byte of a message flagged; every
// third byte, and the flagged byte, yields four characters, the final one of a
// message flagged as last. A byte is taken in the cycle it is offered while the
// group queue (QUEUE_DEPTH groups) has room, so a burst of bytes flows in at
// one per cycle. The character side emits one character per cycle while the
// receiver is ready, four per group, and so sets the sustained rate. The first
// character of a group passes through the group queue, the group register of
// the back end and the character output register before it appears.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [b64se_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                         i_final_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b64se_pkg::CHAR_W-1:0] o_code_char,
    output logic                         o_last_char
);
    import b64se_pkg::*;

    t_queue_status  q_status;
    t_group         push_group;
    t_group         head_group;
    logic           push;
    logic           pop;

    b64se_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_group      (push_group)
    );

    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (push_group),
        .i_pop    (pop),
        .o_group  (head_group),
        .o_status (q_status)
    );

    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_group     (head_group),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_char (o_code_char),
        .o_last_char (o_last_char)
    );

endmodule
